@@ rtl/core/abdd_pkg.sv @@
// Package for the amplitude band duration detector.
// Holds widths, register codes, shared types and the magnitude function.
// No dependencies.
package abdd_pkg;

	localparam int NUM_BANDS   = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 32;

	// fixed by the register map and the result fields
	localparam int BAND_REGS  = 4;
	localparam int LIMIT_BITS = 16;
	localparam int REG_BITS   = 32;
	localparam int OUT_BITS   = 32;
	localparam int IDX_BITS   = 2;
	localparam int CNT_SEL_BITS = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam int ACTIVE_BANDS = (NUM_BANDS < BAND_REGS) ? NUM_BANDS : BAND_REGS;
	localparam int MAG_BITS     = SAMPLE_BITS - 1;
	localparam int CMP_BITS     = (MAG_BITS > LIMIT_BITS) ? MAG_BITS : LIMIT_BITS;
	localparam int WIDE_BITS    = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

	// silence floor: lower*1000 < half scale  <=>  lower < ceil(half scale / 1000)
	localparam longint HALF_SCALE = longint'(1) << MAG_BITS;
	localparam logic [LIMIT_BITS-1:0] FLOOR_LIMIT = LIMIT_BITS'((HALF_SCALE + 999) / 1000);

	typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
	typedef logic [MAG_BITS-1:0]           mag_t;
	typedef logic [LIMIT_BITS-1:0]         limit_t;
	typedef logic [CMP_BITS-1:0]           cmp_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [WIDE_BITS-1:0]          wide_t;
	typedef logic [REG_BITS-1:0]           reg_word_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BAND0          = 3'd0,
		REG_BAND1          = 3'd1,
		REG_BAND2          = 3'd2,
		REG_BAND3          = 3'd3,
		REG_BANDS_IN_USE   = 3'd4,
		REG_GAP_LIMIT      = 3'd5,
		REG_MIN_RUN_LENGTH = 3'd6
	} cfg_reg_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [BAND_REGS-1:0][REG_BITS-1:0] limits;
		logic [CNT_SEL_BITS-1:0]            bands_in_use;
		reg_word_t                          gap_limit;
		reg_word_t                          min_run_length;
	} cfg_t;

	// per-band status toward the priority select
	typedef struct packed {
		logic   emit;
		count_t first;
		count_t length;
	} band_stat_t;

	// magnitude, most negative code saturates to full positive scale
	function automatic mag_t mag_of(pcm_t s);
		pcm_t neg;
		neg = -s;
		if (!s[SAMPLE_BITS-1])
			return s[MAG_BITS-1:0];
		else if (neg[SAMPLE_BITS-1])
			return {MAG_BITS{1'b1}};
		else
			return neg[MAG_BITS-1:0];
	endfunction

endpackage

@@ rtl/core/amplitude_band_duration_detector_top.sv @@
// Top level of the amplitude band duration detector.
// Depends on abdd_pkg, abdd_cfg and abdd_band.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall   | sample
//  out     | source    | out_valid / out_stall | band_index, run_start, run_length,
//          |           |                       | event_number
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low; a sample lands in the input
// register, then the checked bands are evaluated in one pass into the result register.
// Reset clears counters, run state and the valid flags at once; no clearing pass.
// out_stall holds the result word; the input register still takes a new sample
// while the result waits, and in_stall rises only when both registers are full.
// cfg_ready is always high.
module amplitude_band_duration_detector_top import abdd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  pcm_t                    sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IDX_BITS-1:0]     band_index,
	output logic [OUT_BITS-1:0]     run_start,
	output logic [OUT_BITS-1:0]     run_length,
	output logic [OUT_BITS-1:0]     event_number,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  reg_word_t               cfg_data
);

	cfg_t cfg;

	logic   valid_s1;
	mag_t   mag_s1;
	logic   advance;

	count_t sample_index_q;
	count_t events_q;

	band_stat_t                   stat [ACTIVE_BANDS];
	logic [ACTIVE_BANDS-1:0]      checked;
	logic [ACTIVE_BANDS-1:0]      step;
	logic [ACTIVE_BANDS-1:0]      win;
	logic                         emit_any;
	logic [IDX_BITS-1:0]          win_idx;
	count_t                       win_first;
	count_t                       win_length;

	logic                         res_valid_q;
	logic [IDX_BITS-1:0]          band_index_q;
	logic [OUT_BITS-1:0]          run_start_q;
	logic [OUT_BITS-1:0]          run_length_q;
	logic [OUT_BITS-1:0]          event_number_q;

	abdd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves when the result register is free or being taken
	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register holds the magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mag_s1 <= mag_of(sample);
		end
	end

	// band trackers
	for (genvar b = 0; b < ACTIVE_BANDS; b++) begin : g_band
		abdd_band u_band (
			.clk            (clk),
			.arst_n         (arst_n),
			.mag            (mag_s1),
			.lo             (cfg.limits[b][LIMIT_BITS-1:0]),
			.hi             (cfg.limits[b][REG_BITS-1:LIMIT_BITS]),
			.now            (sample_index_q),
			.gap_limit      (cfg.gap_limit),
			.min_run_length (cfg.min_run_length),
			.step           (step[b]),
			.stat           (stat[b])
		);
	end

	// priority: the lowest checked band that emits wins, higher bands skip
	always_comb begin
		logic blocked;
		blocked    = 1'b0;
		win_idx    = '0;
		win_first  = '0;
		win_length = '0;
		for (int b = 0; b < ACTIVE_BANDS; b++) begin
			checked[b] = cfg.bands_in_use > CNT_SEL_BITS'(b);
			step[b]    = advance && checked[b] && !blocked;
			win[b]     = checked[b] && !blocked && stat[b].emit;
			if (win[b]) begin
				win_idx    = IDX_BITS'(b);
				win_first  = stat[b].first;
				win_length = stat[b].length;
			end
			blocked = blocked || win[b];
		end
		emit_any = blocked;
	end

	// sample and event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			events_q       <= '0;
		end else if (advance) begin
			sample_index_q <= sample_index_q + 1'b1;
			if (emit_any) begin
				events_q <= events_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit_any;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_any) begin
			band_index_q   <= win_idx;
			run_start_q    <= OUT_BITS'(win_first);
			run_length_q   <= OUT_BITS'(win_length);
			event_number_q <= OUT_BITS'(events_q);
		end
	end

	assign out_valid    = res_valid_q;
	assign band_index   = band_index_q;
	assign run_start    = run_start_q;
	assign run_length   = run_length_q;
	assign event_number = event_number_q;

	// checks
	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(win))
		else $error("more than one band won the same sample");

	a_event_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit_any) |=> (events_q == $past(events_q) + 1'b1))
		else $error("event counter did not follow an emitted word");

	a_index_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(sample_index_q))
		else $error("sample index moved without a sample");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

endmodule

@@ rtl/core/abdd_cfg.sv @@
// Configuration register file for the amplitude band duration detector.
// Depends on abdd_pkg.
module abdd_cfg import abdd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  reg_word_t               cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limits         <= '0;
			cfg_q.bands_in_use   <= CNT_SEL_BITS'(1);
			cfg_q.gap_limit      <= '0;
			cfg_q.min_run_length <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				[REG_BAND0:REG_BAND3]: begin
					cfg_q.limits[cfg_index[IDX_BITS-1:0]] <= cfg_data;
				end
				REG_BANDS_IN_USE: begin
					cfg_q.bands_in_use <= cfg_data[CNT_SEL_BITS-1:0];
				end
				REG_GAP_LIMIT: begin
					cfg_q.gap_limit <= cfg_data;
				end
				REG_MIN_RUN_LENGTH: begin
					cfg_q.min_run_length <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/abdd_band.sv @@
// Run tracker for one amplitude band: run state, end detection, event check.
// Depends on abdd_pkg.
module abdd_band import abdd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mag_t       mag,
	input  limit_t     lo,
	input  limit_t     hi,
	input  count_t     now,
	input  reg_word_t  gap_limit,
	input  reg_word_t  min_run_length,
	input  logic       step,
	output band_stat_t stat
);

	logic   active_q;
	count_t first_q;
	count_t last_q;

	logic   in_band;
	logic   floor_band;
	logic   run_ends;
	count_t gap;
	count_t span;

	// band match and run end test
	always_comb begin
		in_band    = (cmp_t'(lo) <= cmp_t'(mag)) && (cmp_t'(mag) <= cmp_t'(hi));
		floor_band = lo < FLOOR_LIMIT;
		gap        = now - last_q;
		span       = now - first_q;
		run_ends   = !in_band && active_q &&
		             (floor_band || (wide_t'(gap) > wide_t'(gap_limit)));
		stat.emit   = run_ends && (wide_t'(span) >= wide_t'(min_run_length));
		stat.first  = first_q;
		stat.length = last_q - first_q;
	end

	// run state update, only when this band is processed for the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= '0;
			last_q   <= '0;
		end else if (step) begin
			if (in_band) begin
				if (!active_q) begin
					first_q <= now;
				end
				active_q <= 1'b1;
				last_q   <= now;
			end else if (run_ends) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for amplitude_band_duration_detector_top.
// Predicts band run events in a small class and checks each result word, field by field.
// Depends on abdd_pkg and the detector RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import abdd_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 150;
	localparam int MAX_IDLE      = 17;
	localparam int RANDOM_ITEMS  = 750;
	localparam int MAG_MAX       = (1 << MAG_BITS) - 1;
	localparam pcm_t MOST_NEG = {1'b1, {MAG_BITS{1'b0}}};
	localparam pcm_t MOST_POS = {1'b0, {MAG_BITS{1'b1}}};

	typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] band;
		logic [OUT_BITS-1:0] start;
		logic [OUT_BITS-1:0] length;
		logic [OUT_BITS-1:0] number;
	} band_event_t;

	// Tracks the register copy and per-band runs, and holds the events still due.
	class event_board_t;
		reg_word_t   limits[BAND_REGS];
		int unsigned bands_on;
		reg_word_t   gap_limit;
		reg_word_t   min_run;
		count_t      sample_count;
		count_t      event_count;
		bit          run_on[NUM_BANDS];
		count_t      run_first[NUM_BANDS];
		count_t      run_last[NUM_BANDS];
		band_event_t due_events[$];
		int          mismatches;
		int          events_checked;
		int          samples_seen;

		function new();
			foreach (limits[b])
				limits[b] = '0;
			foreach (run_on[b]) begin
				run_on[b]    = 1'b0;
				run_first[b] = '0;
				run_last[b]  = '0;
			end
			bands_on       = 1;
			gap_limit      = '0;
			min_run        = '0;
			sample_count   = '0;
			event_count    = '0;
			mismatches     = 0;
			events_checked = 0;
			samples_seen   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, reg_word_t data);
			case (idx)
				REG_BAND0, REG_BAND1, REG_BAND2, REG_BAND3: limits[idx] = data;
				REG_BANDS_IN_USE:   bands_on  = data[CNT_SEL_BITS-1:0];
				REG_GAP_LIMIT:      gap_limit = data;
				REG_MIN_RUN_LENGTH: min_run   = data;
				default: ;
			endcase
		endfunction

		// one accepted sample: update the checked bands in order up to the first event, which wins
		function void note_sample(pcm_t s);
			int          level;
			int unsigned mag;
			int unsigned lo;
			int unsigned hi;
			int unsigned count;
			int          b;
			bit          emitted;
			bit          floor_band;
			count_t      gap;
			count_t      span;
			level = s;
			mag = (level < 0) ? -level : level;
			if (mag > MAG_MAX)
				mag = MAG_MAX;
			count = bands_on;
			if (count > BAND_REGS)
				count = BAND_REGS;
			if (count > NUM_BANDS)
				count = NUM_BANDS;
			emitted = 1'b0;
			samples_seen++;
			for (b = 0; b < count && !emitted; b++) begin
				lo = limits[b][LIMIT_BITS-1:0];
				hi = limits[b][2*LIMIT_BITS-1:LIMIT_BITS];
				if (lo <= mag && mag <= hi) begin
					if (!run_on[b]) begin
						run_on[b]    = 1'b1;
						run_first[b] = sample_count;
					end
					run_last[b] = sample_count;
				end else if (run_on[b]) begin
					// bands starting below 0.001 of full scale end on the first miss
					floor_band = (longint'(lo) * 1000) < (longint'(1) << MAG_BITS);
					gap = sample_count - run_last[b];
					if (floor_band || gap > gap_limit) begin
						run_on[b] = 1'b0;
						span = sample_count - run_first[b];
						if (span >= min_run) begin
							due_events.insert(due_events.size(), band_event_t'{IDX_BITS'(b),
								OUT_BITS'(run_first[b]),
								OUT_BITS'(run_last[b] - run_first[b]),
								OUT_BITS'(event_count)});
							event_count++;
							emitted = 1'b1;
						end
					end
				end
			end
			sample_count++;
		endfunction

		task report(string field, longint got, longint want);
			mismatches++;
			if (mismatches <= 50)
				$display("%0t: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
		endtask

		task check_event(band_event_t got);
			band_event_t want;
			if (due_events.size() == 0) begin
				report("event_number of a word with no event due", got.number, -1);
				return;
			end
			want = due_events.pop_front();
			events_checked++;
			if (got.band != want.band)
				report("band_index", got.band, want.band);
			if (got.start != want.start)
				report("run_start", got.start, want.start);
			if (got.length != want.length)
				report("run_length", got.length, want.length);
			if (got.number != want.number)
				report("event_number", got.number, want.number);
		endtask

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	pcm_t                    sample;
	logic                    out_valid;
	logic                    out_stall;
	logic [IDX_BITS-1:0]     band_index;
	logic [OUT_BITS-1:0]     run_start;
	logic [OUT_BITS-1:0]     run_length;
	logic [OUT_BITS-1:0]     event_number;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	reg_word_t               cfg_data;

	event_board_t      board;
	idle_mode_t        send_mode;
	idle_mode_t        recv_mode;
	int                hold_request;
	int                stalled_cycles;
	int                reg_writes;

	amplitude_band_duration_detector_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.band_index   (band_index),
		.run_start    (run_start),
		.run_length   (run_length),
		.event_number (event_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.write_reg(cfg_index, cfg_data);
				reg_writes++;
			end
			if (in_valid && !in_stall)
				board.note_sample(sample);
			if (in_valid && in_stall)
				stalled_cycles++;
			if (out_valid && !out_stall)
				board.check_event(band_event_t'{band_index, run_start, run_length, event_number});
		end
	end

	// ends the run if no word moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no word moved for %0d cycles", QUIET_LIMIT);
		$display("tb failed");
		$finish;
	end

	function automatic int draw_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE:   return 0;
			IDLE_SPARSE: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
			default:     return $urandom_range(0, MAX_IDLE);
		endcase
	endfunction

	// result side: stall a drawn number of cycles per word, or a long hold when asked
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end else begin
				hold = draw_idle(recv_mode);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	function automatic reg_word_t limits_of(int unsigned lo, int unsigned hi);
		return {hi[LIMIT_BITS-1:0], lo[LIMIT_BITS-1:0]};
	endfunction

	function automatic pcm_t signed_mag(int unsigned mag);
		if (mag == MAG_MAX && $urandom_range(0, 3) == 0)
			return MOST_NEG;
		if ($urandom_range(0, 1) != 0)
			return pcm_t'(-int'(mag));
		return pcm_t'(mag);
	endfunction

	function automatic pcm_t in_band_sample(int b);
		int unsigned lo;
		int unsigned hi;
		lo = board.limits[b][LIMIT_BITS-1:0];
		hi = board.limits[b][2*LIMIT_BITS-1:LIMIT_BITS];
		if (hi > MAG_MAX)
			hi = MAG_MAX;
		if (lo > hi)
			return pcm_t'($urandom());
		return signed_mag($urandom_range(lo, hi));
	endfunction

	function automatic pcm_t out_band_sample(int b);
		int unsigned lo;
		int unsigned hi;
		bit          below;
		bit          above;
		lo = board.limits[b][LIMIT_BITS-1:0];
		hi = board.limits[b][2*LIMIT_BITS-1:LIMIT_BITS];
		below = lo > 0;
		above = hi < MAG_MAX;
		if (below && (!above || $urandom_range(0, 1) != 0))
			return signed_mag($urandom_range(0, (lo - 1 > MAG_MAX) ? MAG_MAX : lo - 1));
		if (above)
			return signed_mag($urandom_range(hi + 1, MAG_MAX));
		return pcm_t'($urandom());
	endfunction

	function automatic reg_word_t pick_limits();
		int unsigned lo;
		int unsigned hi;
		case ($urandom_range(0, 7))
			0, 1: begin
				lo = $urandom_range(0, 32);
				hi = lo + $urandom_range(0, 3000);
			end
			2, 3: begin
				lo = $urandom_range(33, 24000);
				hi = lo + $urandom_range(0, 6000);
			end
			4: begin
				lo = $urandom_range(31, 34);
				hi = $urandom_range(40, 2000);
			end
			5: begin
				lo = $urandom_range(16000, MAG_MAX);
				hi = 16'hFFFF;
			end
			6: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return 32'hFFFF_FFFF;
					default: return 32'hFFFF_0000;
				endcase
			end
			default: return $urandom();
		endcase
		if (hi > 16'hFFFF)
			hi = 16'hFFFF;
		return limits_of(lo, hi);
	endfunction

	// offers one word, drawing the idle cycles first; entered and left at a falling edge
	task automatic send_sample(pcm_t s);
		int gap;
		gap = draw_idle(send_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering and wait until every due event has arrived and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, reg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_config();
		int        b;
		reg_word_t data;
		for (b = 0; b < BAND_REGS; b++)
			write_reg(CFG_IDX_BITS'(REG_BAND0 + b), pick_limits());
		data = $urandom();
		case ($urandom_range(0, 9))
			7:       data[CNT_SEL_BITS-1:0] = '0;
			8, 9:    data[CNT_SEL_BITS-1:0] = $urandom_range(BAND_REGS + 1, 7);
			default: data[CNT_SEL_BITS-1:0] = $urandom_range(1, BAND_REGS);
		endcase
		write_reg(REG_BANDS_IN_USE, data);
		case ($urandom_range(0, 7))
			0, 1:    data = '0;
			2, 3:    data = $urandom_range(1, 6);
			4, 5:    data = $urandom_range(7, 30);
			6:       data = 32'hFFFF_FFFF;
			default: data = $urandom();
		endcase
		write_reg(REG_GAP_LIMIT, data);
		case ($urandom_range(0, 7))
			0, 1, 2: data = '0;
			3, 4:    data = $urandom_range(1, 12);
			5:       data = $urandom_range(13, 60);
			6:       data = 32'hFFFF_FFFF;
			default: data = $urandom();
		endcase
		write_reg(REG_MIN_RUN_LENGTH, data);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, $urandom());
		cfg_valid <= 1'b0;
	endtask

	// a run inside band b with short dips, closed by a tail of misses
	task automatic send_run(int b);
		int len;
		int dip_max;
		int tail;
		int k;
		len = $urandom_range(1, 24);
		dip_max = (board.gap_limit < 6) ? int'(board.gap_limit) : 6;
		for (k = 0; k < len; k++) begin
			send_sample(in_band_sample(b));
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(0, dip_max)) send_sample(out_band_sample(b));
		end
		if (board.gap_limit < 40)
			tail = int'(board.gap_limit) + 1 + $urandom_range(0, 2);
		else
			tail = $urandom_range(1, 4);
		repeat (tail) send_sample(out_band_sample(b));
	endtask

	task automatic random_phase(int items);
		int stop;
		int top;
		stop = board.samples_seen + items;
		top = board.bands_on;
		if (top < 1)
			top = 1;
		if (top > BAND_REGS)
			top = BAND_REGS;
		while (board.samples_seen < stop) begin
			if ($urandom_range(0, 9) < 7)
				send_run($urandom_range(0, top - 1));
			else
				repeat ($urandom_range(1, 6)) send_sample(pcm_t'($urandom()));
		end
	endtask

	initial begin : stimulus
		in_valid       = 1'b0;
		sample         = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		arst_n         = 1'b0;
		send_mode      = IDLE_SPARSE;
		recv_mode      = IDLE_SPARSE;
		hold_request   = 0;
		stalled_cycles = 0;
		reg_writes     = 0;
		board          = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: band 0 matches silence only
		send_sample('0);
		send_sample('0);
		send_sample(pcm_t'(1));
		send_sample(MOST_NEG);
		drain();

		// top of scale, floor boundary on both sides, and a one-code band
		write_reg(REG_BAND0, limits_of(MAG_MAX, MAG_MAX));
		write_reg(REG_BAND1, limits_of(33, 40));
		write_reg(REG_BAND2, limits_of(32, 32));
		write_reg(REG_BAND3, limits_of(1, 1));
		write_reg(REG_BANDS_IN_USE, BAND_REGS);
		write_reg(REG_GAP_LIMIT, '0);
		write_reg(REG_MIN_RUN_LENGTH, '0);
		cfg_valid <= 1'b0;
		send_sample(MOST_NEG);
		send_sample(MOST_POS);
		send_sample(pcm_t'(-1));    // band 0 event blocks the band 3 update
		send_sample(pcm_t'(33));
		send_sample(pcm_t'(-33));
		send_sample(pcm_t'(32));
		send_sample(pcm_t'(-32));
		send_sample('0);
		send_sample(pcm_t'(1));
		drain();

		// only band 0 checked: the band 3 run must sit untouched
		write_reg(REG_BANDS_IN_USE, 1);
		cfg_valid <= 1'b0;
		send_sample(pcm_t'(500));
		send_sample(MOST_POS);
		send_sample(pcm_t'(-MAG_MAX));
		drain();

		// band count above range, widest gap and run length, spare index ignored
		write_reg(REG_BANDS_IN_USE, 32'hFFFF_FFFF);
		write_reg(REG_GAP_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_MIN_RUN_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, $urandom());
		cfg_valid <= 1'b0;
		send_sample(pcm_t'(500));
		send_sample(pcm_t'(33));
		drain();

		// no band checked
		write_reg(REG_BANDS_IN_USE, reg_word_t'($urandom()) & ~reg_word_t'(7));
		write_reg(REG_GAP_LIMIT, '0);
		write_reg(REG_MIN_RUN_LENGTH, '0);
		cfg_valid <= 1'b0;
		send_sample(pcm_t'(33));
		send_sample(pcm_t'(-1));
		send_sample(MOST_NEG);
		drain();

		// back pressure: an event every other word while the result side holds off
		write_reg(REG_BAND0, limits_of(0, 100));
		write_reg(REG_BANDS_IN_USE, 1);
		cfg_valid <= 1'b0;
		send_mode    = IDLE_NONE;
		recv_mode    = IDLE_NONE;
		hold_request = LONG_HOLD;
		repeat (30) begin
			send_sample(signed_mag($urandom_range(0, 100)));
			send_sample(signed_mag($urandom_range(20000, MAG_MAX)));
		end
		drain();

		// random settings, each followed by mostly well-formed runs
		while (board.samples_seen < RANDOM_ITEMS) begin
			random_config();
			send_mode = idle_mode_t'($urandom_range(0, 2));
			recv_mode = idle_mode_t'($urandom_range(0, 2));
			random_phase($urandom_range(30, 90));
			drain();
		end

		$display("%0d samples and %0d register writes across many band settings, %0d events",
			board.samples_seen, reg_writes, board.events_checked);
		$display("input held off by the block on %0d cycles, %0d mismatches",
			stalled_cycles, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
